// ===== hw/rtl/bmhq_pkg.sv =====
// Shared types and constants for the binary max-heap priority queue.
package bmhq_pkg;

  localparam int KEY_W = 32;
  localparam int CNT_OUT_W = 7;

  localparam logic CMD_INSERT  = 1'b0;
  localparam logic CMD_EXTRACT = 1'b1;

  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic                    done;
    logic signed [KEY_W-1:0] key;
    logic                    empty;
    logic                    full;
    logic [CNT_OUT_W-1:0]    count;
  } res_t;

endpackage

// ===== hw/rtl/binary_max_heap_queue.sv =====
// Top level of the binary max-heap priority queue of signed 32-bit keys.
//
// A command is transferred when start is high and busy is low. in_cmd selects
// insert of in_key_in or extract of the largest key held. Each command gives
// exactly one result, shown for one cycle while out_valid is high; the
// receiver cannot stall, so each result is taken in the cycle it appears.
// out_entry_count holds the number of keys held after the command.
// Extract on an empty heap returns 2147483647 with out_was_empty set; insert
// on a full heap drops the key and sets out_was_full.
// A full or empty case gives its result without making busy rise. Insert
// climbs the key level by level, reading the parent and moving it down while
// it is smaller than the key. Extract reads the root and the last key, then
// sinks the last key from the root, reading the left and right children,
// picking the larger and moving it up while the key is smaller than it.
// The steps are paced by the single read port of the key store and the one
// comparator that all the compare steps share. busy stays high until the
// result is ready; a new command may be transferred in the cycle it shows.
// Reset empties the heap; the store itself is not cleared.
module binary_max_heap_queue
  import bmhq_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_cmd,
  input  logic signed [KEY_W-1:0]     in_key_in,
  output logic                        out_valid,
  output logic signed [KEY_W-1:0]     out_key_out,
  output logic                        out_was_empty,
  output logic                        out_was_full,
  output logic [CNT_OUT_W-1:0]        out_entry_count
);

  localparam int AW = $clog2(CAPACITY);

  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [KEY_W-1:0] ram_wdata, ram_rdata;
  res_t            res;
  logic            seq_busy;

  bmhq_seq #(.CAPACITY(CAPACITY)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .cmd       (in_cmd),
    .key       (in_key_in),
    .busy      (seq_busy),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .res       (res)
  );

  bmhq_ram #(.W(KEY_W), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy            = seq_busy;
  assign out_valid       = res.done;
  assign out_key_out     = res.key;
  assign out_was_empty   = res.empty;
  assign out_was_full    = res.full;
  assign out_entry_count = res.count;

endmodule

// ===== hw/rtl/bmhq_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module bmhq_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/bmhq_seq.sv =====
// Heap sequencer: sift-up and sift-down steps around one shared key comparator.
module bmhq_seq
  import bmhq_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        cmd,
  input  logic signed [KEY_W-1:0]     key,
  output logic                        busy,
  output logic                        ram_we,
  output logic [$clog2(CAPACITY)-1:0] ram_waddr,
  output logic [KEY_W-1:0]            ram_wdata,
  output logic [$clog2(CAPACITY)-1:0] ram_raddr,
  input  logic [KEY_W-1:0]            ram_rdata,
  output res_t                        res
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = CW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_UP_CHK, S_UP_WAIT, S_EX_TOP, S_EX_LAST,
    S_DN_CHK, S_DN_L, S_DN_R, S_DN_CMP
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic [PW-1:0]           pos_r, pos_nxt;
  logic [PW-1:0]           kid_r, kid_nxt;
  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic signed [KEY_W-1:0] top_r, top_nxt;
  logic signed [KEY_W-1:0] lv_r, lv_nxt;
  logic signed [KEY_W-1:0] cv_r, cv_nxt;
  res_t                    res_r, res_nxt;

  logic signed [KEY_W-1:0] cmp_a, cmp_b, rd_key;
  logic                    lt;
  logic [PW-1:0]           pos_m1, par_m1, cnt_m1, cnt_w;

  assign rd_key = ram_rdata;
  assign lt     = cmp_a < cmp_b;
  assign cnt_w  = PW'(count_r);
  assign pos_m1 = pos_r - PW'(1);
  assign par_m1 = (pos_r >> 1) - PW'(1);
  assign cnt_m1 = cnt_w - PW'(1);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    pos_nxt   = pos_r;
    kid_nxt   = kid_r;
    key_nxt   = key_r;
    top_nxt   = top_r;
    lv_nxt    = lv_r;
    cv_nxt    = cv_r;
    res_nxt   = '0;
    ram_we    = 1'b0;
    ram_waddr = pos_m1[AW-1:0];
    ram_wdata = key_r;
    ram_raddr = '0;
    cmp_a     = key_r;
    cmp_b     = cv_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          key_nxt = key;
          if (cmd == CMD_INSERT) begin
            if (cnt_w == PW'(CAPACITY)) begin
              res_nxt.done = 1'b1;
              res_nxt.full = 1'b1;
              res_nxt.count = CNT_OUT_W'(count_r);
            end else begin
              count_nxt = count_r + CW'(1);
              pos_nxt = cnt_w + PW'(1);
              state_nxt = S_UP_CHK;
            end
          end else begin
            if (count_r == '0) begin
              res_nxt.done = 1'b1;
              res_nxt.empty = 1'b1;
              res_nxt.key = KEY_MAX;
              res_nxt.count = CNT_OUT_W'(count_r);
            end else begin
              state_nxt = S_EX_TOP;
            end
          end
        end
      end
      S_UP_CHK: begin
        ram_raddr = par_m1[AW-1:0];
        if (pos_r > PW'(1)) begin
          state_nxt = S_UP_WAIT;
        end else begin
          ram_we = 1'b1;
          res_nxt.done = 1'b1;
          res_nxt.count = CNT_OUT_W'(count_r);
          state_nxt = S_IDLE;
        end
      end
      S_UP_WAIT: begin
        cmp_a = rd_key;
        cmp_b = key_r;
        ram_we = 1'b1;
        if (lt) begin
          ram_wdata = rd_key;
          pos_nxt = pos_r >> 1;
          state_nxt = S_UP_CHK;
        end else begin
          res_nxt.done = 1'b1;
          res_nxt.count = CNT_OUT_W'(count_r);
          state_nxt = S_IDLE;
        end
      end
      S_EX_TOP: begin
        top_nxt = rd_key;
        ram_raddr = cnt_m1[AW-1:0];
        state_nxt = S_EX_LAST;
      end
      S_EX_LAST: begin
        key_nxt = rd_key;
        count_nxt = count_r - CW'(1);
        pos_nxt = PW'(1);
        state_nxt = S_DN_CHK;
      end
      S_DN_CHK: begin
        kid_nxt = pos_r << 1;
        ram_raddr = AW'((pos_r << 1) - PW'(1));
        if ((pos_r << 1) <= cnt_w) begin
          state_nxt = S_DN_L;
        end else begin
          ram_we = 1'b1;
          res_nxt.done = 1'b1;
          res_nxt.key = top_r;
          res_nxt.count = CNT_OUT_W'(count_r);
          state_nxt = S_IDLE;
        end
      end
      S_DN_L: begin
        lv_nxt = rd_key;
        ram_raddr = kid_r[AW-1:0];
        if (kid_r != cnt_w) begin
          state_nxt = S_DN_R;
        end else begin
          cv_nxt = rd_key;
          state_nxt = S_DN_CMP;
        end
      end
      S_DN_R: begin
        cmp_a = lv_r;
        cmp_b = rd_key;
        if (lt) begin
          cv_nxt = rd_key;
          kid_nxt = kid_r + PW'(1);
        end else begin
          cv_nxt = lv_r;
        end
        state_nxt = S_DN_CMP;
      end
      S_DN_CMP: begin
        ram_we = 1'b1;
        if (lt) begin
          ram_wdata = cv_r;
          pos_nxt = kid_r;
          state_nxt = S_DN_CHK;
        end else begin
          res_nxt.done = 1'b1;
          res_nxt.key = top_r;
          res_nxt.count = CNT_OUT_W'(count_r);
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      res_r   <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      res_r   <= res_nxt;
    end
    pos_r <= pos_nxt;
    kid_r <= kid_nxt;
    key_r <= key_nxt;
    top_r <= top_nxt;
    lv_r  <= lv_nxt;
    cv_r  <= cv_nxt;
  end

  assign busy = (state_r != S_IDLE);
  assign res  = res_r;

endmodule
